>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on the rising clock edge, with the asynchronous reset
// masking them. Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define HBP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("huffman bit packer: property violated");
// Check that a condition never holds outside reset.
`define HBP_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("huffman bit packer: forbidden condition seen");
`else
`define HBP_ASSERT(lbl, clk, rstn, prop)
`define HBP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> src/hbp_pkg.sv
// ---------------------------------------------------------------------------
// hbp_pkg
// Field widths, action codes and the result bundle of the bit packer.
// ---------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

	// Fixed widths of the item fields
	localparam int ACTION_W = 2;
	localparam int SYMBOL_W = 8;
	localparam int CODE_W   = 32;
	localparam int LENGTH_W = 6;
	localparam int BYTE_W   = 8;

	// Parameter defaults
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int SYMBOL_COUNT_DEF = 256;

	// Pending bit buffer
	localparam int PEND_W     = 7;
	localparam int PEND_CNT_W = 3;

	// Result bundle: at most four bytes per item
	localparam int OUT_SLOTS  = 4;
	localparam int SLOT_CNT_W = 3;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

	// Bytes produced by one item, slot 0 leaves first
	typedef struct packed {
		logic [OUT_SLOTS-1:0][BYTE_W-1:0] bytes;
		logic [SLOT_CNT_W-1:0]            count;
		logic                             final_mark;
	} emit_t;

endpackage

`default_nettype wire

>>> src/hbp_in_if.sv
// ---------------------------------------------------------------------------
// hbp_in_if
// Command channel: load, encode and flush items with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface hbp_in_if;
	import hbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [SYMBOL_W-1:0] symbol;
	logic [CODE_W-1:0]   code_word;
	logic [LENGTH_W-1:0] code_length;

	modport source (
		output valid, action, symbol, code_word, code_length,
		input  ready
	);

	modport sink (
		input  valid, action, symbol, code_word, code_length,
		output ready
	);
endinterface

`default_nettype wire

>>> src/hbp_out_if.sv
// ---------------------------------------------------------------------------
// hbp_out_if
// Byte stream channel: packed bytes with a final mark, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface hbp_out_if;
	import hbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              final_byte;

	modport source (
		output valid, out_byte, final_byte,
		input  ready
	);

	modport sink (
		input  valid, out_byte, final_byte,
		output ready
	);
endinterface

`default_nettype wire

>>> src/hbp_code_table.sv
// ---------------------------------------------------------------------------
// hbp_code_table
// Code word and length per symbol in one synchronous memory, one write
// port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module hbp_code_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int CW    = 32,
	parameter int LW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [CW-1:0] wr_code,
	input  logic [LW-1:0] wr_len,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [CW-1:0] rd_code,
	output logic [LW-1:0] rd_len
);
	logic [CW+LW-1:0] mem [DEPTH];
	logic [CW+LW-1:0] rd_q;

	// Write a loaded entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_code, wr_len};
		end
	end

	// Read an entry into the registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_code = rd_q[CW+LW-1:LW];
	assign rd_len  = rd_q[LW-1:0];
endmodule

`default_nettype wire

>>> src/hbp_packer.sv
// ---------------------------------------------------------------------------
// hbp_packer
// Holds the pending bits, appends a looked-up code and splits off every
// completed byte; on flush, forms the partial byte and the padding count.
// ---------------------------------------------------------------------------
`default_nettype none

module hbp_packer #(
	parameter int CW = 32,
	parameter int LW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            is_flush,
	input  logic [CW-1:0]   code,
	input  logic [LW-1:0]   len,
	output hbp_pkg::emit_t  emit
);
	import hbp_pkg::*;

	localparam int ACCW      = PEND_W + CW;
	localparam int TW        = $clog2(ACCW + 1);
	localparam int ALW       = ((ACCW + BYTE_W - 1) / BYTE_W) * BYTE_W;
	localparam int SLOT_BITS = OUT_SLOTS * BYTE_W;

	logic [PEND_W-1:0]         pend_q;
	logic [PEND_CNT_W-1:0]     pend_cnt_q;
	logic [ACCW-1:0]           acc;
	logic [TW-1:0]             total;
	logic [PEND_CNT_W-1:0]     rem;
	logic [ACCW+ALW-1:0]       wide;
	logic [ALW+SLOT_BITS-1:0]  ext;
	logic [PEND_W-1:0]         new_pend;
	logic [BYTE_W-1:0]         part_byte;
	logic [BYTE_W-1:0]         pad_byte;

	// Append the code below the pending bits
	always_comb begin
		acc      = (ACCW'(pend_q) << len) | ACCW'(code);
		total    = TW'(pend_cnt_q) + TW'(len);
		rem      = total[PEND_CNT_W-1:0];
		wide     = {acc, {ALW{1'b0}}} >> total;
		ext      = {wide[ALW-1:0], {SLOT_BITS{1'b0}}};
		new_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
	end

	// Form the flush bytes
	always_comb begin
		part_byte = {1'b0, pend_q} << (4'(BYTE_W) - {1'b0, pend_cnt_q});
		pad_byte  = 8'(BYTE_W) - {{(BYTE_W-PEND_CNT_W){1'b0}}, pend_cnt_q};
	end

	// Build the result bundle
	always_comb begin
		emit = '0;
		if (is_flush) begin
			emit.final_mark = 1'b1;
			if (pend_cnt_q != '0) begin
				emit.bytes[0] = part_byte;
				emit.bytes[1] = pad_byte;
				emit.count    = SLOT_CNT_W'(2);
			end else begin
				emit.bytes[0] = pad_byte;
				emit.count    = SLOT_CNT_W'(1);
			end
		end else begin
			for (int k = 0; k < OUT_SLOTS; k++) begin
				emit.bytes[k] = ext[ALW+SLOT_BITS-1-BYTE_W*k -: BYTE_W];
			end
			emit.count = SLOT_CNT_W'(total >> 3);
		end
	end

	// Advance the pending bits, clear them on flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
		end else if (adv) begin
			if (is_flush) begin
				pend_q     <= '0;
				pend_cnt_q <= '0;
			end else begin
				pend_q     <= new_pend;
				pend_cnt_q <= rem;
			end
		end
	end
endmodule

`default_nettype wire

>>> src/hbp_out_buf.sv
// ---------------------------------------------------------------------------
// hbp_out_buf
// Output register bank: takes the bytes of one item and sends them one per
// cycle on the byte stream while the stream is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module hbp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hbp_pkg::emit_t    din,
	output logic              free,
	hbp_out_if.source         stream
);
	import hbp_pkg::*;

	logic [OUT_SLOTS*BYTE_W-1:0] bytes_q;
	logic [SLOT_CNT_W-1:0]       cnt_q;
	logic                        final_q;
	logic                        take;

	assign take = stream.valid && stream.ready;
	assign free = (cnt_q == '0) || ((cnt_q == SLOT_CNT_W'(1)) && stream.ready);

	// Hold the byte count and the final mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			final_q <= 1'b0;
		end else if (load) begin
			cnt_q   <= din.count;
			final_q <= din.final_mark;
		end else if (take) begin
			cnt_q <= cnt_q - SLOT_CNT_W'(1);
		end
	end

	// Load or shift the byte slots
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= din.bytes;
		end else if (take) begin
			bytes_q <= bytes_q >> BYTE_W;
		end
	end

	assign stream.valid      = (cnt_q != '0);
	assign stream.out_byte   = bytes_q[BYTE_W-1:0];
	assign stream.final_byte = final_q && (cnt_q == SLOT_CNT_W'(1));
endmodule

`default_nettype wire

>>> src/huffman_bit_packer.sv
// ---------------------------------------------------------------------------
// huffman_bit_packer
// Table-driven code packer: loads a per-symbol code table, packs codes
// MSB-first into bytes and closes a stream with a padding-count byte.
// ---------------------------------------------------------------------------
// A load item writes its entry into the code table memory in the cycle it
// is accepted; an encode item reads the table in that same cycle, so an
// encode may directly follow the load of its own symbol. An item that
// yields at most one byte lets items follow back to back while the
// stream is ready. An item that yields n bytes (up to four for a 32-bit
// code, two for a flush) stalls the next item that yields bytes until
// its own last byte leaves; the output register bank sends one byte per
// cycle while ready. Codes pass the table read and then the output register.
// The table has no reset; encoding a symbol never loaded gives undefined
// bytes. Loads and encodes of symbols at or above SYMBOL_COUNT, and the
// unused action code, are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_bit_packer #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hbp_in_if.sink     cmd,
	hbp_out_if.source  stream
);
	import hbp_pkg::*;
	`include "assert_macros.svh"

	localparam int CW = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LW = $clog2(CW + 1);
	localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam logic [SYMBOL_W:0]   SYM_LIMIT = (SYMBOL_W + 1)'(SYMBOL_COUNT);
	localparam logic [LENGTH_W-1:0] LEN_LIMIT = LENGTH_W'(CW);
	localparam logic [LENGTH_W-1:0] FULL_LEN  = LENGTH_W'(CODE_W);

	logic              cmd_acc;
	logic              in_range;
	logic              wr_en;
	logic              enc_go;
	logic              fl_go;
	logic [LENGTH_W-1:0] sat_len;
	logic [CODE_W-1:0] code_mask;
	logic [CODE_W-1:0] masked_code;
	logic [CW-1:0]     rd_code;
	logic [LW-1:0]     rd_len;
	logic              s1_valid_q;
	logic              flush_s1;
	logic              s1_adv;
	logic              buf_free;
	logic              buf_load;
	emit_t             emit;

	// Decode the accepted item
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign in_range = ({1'b0, cmd.symbol} < SYM_LIMIT);
	assign wr_en    = cmd_acc && in_range && (cmd.action == ACT_LOAD);
	assign enc_go   = cmd_acc && in_range && (cmd.action == ACT_ENCODE);
	assign fl_go    = cmd_acc && (cmd.action == ACT_FLUSH);

	// Saturate the length and drop code bits above it
	always_comb begin
		sat_len     = (cmd.code_length > LEN_LIMIT) ? LEN_LIMIT : cmd.code_length;
		code_mask   = (sat_len >= FULL_LEN) ? {CODE_W{1'b1}}
			: ~({CODE_W{1'b1}} << sat_len);
		masked_code = cmd.code_word & code_mask;
	end

	hbp_code_table #(
		.DEPTH (SYMBOL_COUNT),
		.AW    (AW),
		.CW    (CW),
		.LW    (LW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cmd.symbol[AW-1:0]),
		.wr_code (masked_code[CW-1:0]),
		.wr_len  (sat_len[LW-1:0]),
		.rd_en   (enc_go),
		.rd_addr (cmd.symbol[AW-1:0]),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	// Advance the lookup stage when its bytes fit in the output bank
	assign s1_adv    = s1_valid_q && ((emit.count == '0) || buf_free);
	assign buf_load  = s1_adv && (emit.count != '0);
	assign cmd.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			flush_s1   <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= enc_go || fl_go;
			flush_s1   <= fl_go;
		end
	end

	hbp_packer #(
		.CW (CW),
		.LW (LW)
	) u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (s1_adv),
		.is_flush (flush_s1),
		.code     (rd_code),
		.len      (rd_len),
		.emit     (emit)
	);

	hbp_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (buf_load),
		.din    (emit),
		.free   (buf_free),
		.stream (stream)
	);

	// A stalled lookup stage keeps its item
	`HBP_ASSERT(a_stall_holds, clk, arst_n, s1_valid_q && !s1_adv |=> s1_valid_q)
	// The output bank is loaded only when its last byte leaves or it is empty
	`HBP_ASSERT(a_load_when_free, clk, arst_n, buf_load |-> buf_free)
	// A flush always yields the padding byte
	`HBP_ASSERT_NEVER(a_flush_emits, clk, arst_n, s1_valid_q && flush_s1 && emit.count == '0)
	// An encode never yields more bytes than the bank holds
	`HBP_ASSERT(a_count_bound, clk, arst_n, buf_load |-> emit.count <= SLOT_CNT_W'(OUT_SLOTS))
endmodule

`default_nettype wire
